// ===== rtl/plie_pkg.sv =====
// Package for the positional list: opcodes, status codes, FSM states and
// the control word broadcast along the cell chain. No dependencies.
package plie_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 17;  // covers every position up to the largest capacity
  localparam int FIELD_POS_W    = 11;
  localparam int VALUE_W        = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_ERASE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_SET
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== rtl/plie_if.sv =====
// Handshake channels of the positional list: one beat per operation in,
// one beat per result out. Depends on plie_pkg for field widths.
interface plie_in_if;
  import plie_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [FIELD_POS_W-1:0] position;
  logic [FIELD_POS_W-1:0] count;
  logic signed [VALUE_W-1:0] value;
  logic                   run_last;
  modport source (output valid, opcode, position, count, value, run_last, input ready);
  modport sink   (input valid, opcode, position, count, value, run_last, output ready);
endinterface

interface plie_out_if;
  import plie_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [FIELD_POS_W-1:0]    list_length;
  logic [1:0]                status;
  modport source (output valid, read_value, list_length, status, input ready);
  modport sink   (input valid, read_value, list_length, status, output ready);
endinterface

// ===== rtl/plie_cell.sv =====
// One storage cell of the list chain; takes its left or right neighbour,
// the write value, or holds. Depends on plie_pkg.
module plie_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = plie_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  plie_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]  wr_val,
  input  logic [DATA_WIDTH-1:0]  prev_q,
  input  logic [DATA_WIDTH-1:0]  next_q,
  output logic [DATA_WIDTH-1:0]  q
);
  import plie_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_INS: begin
        if (MY_IDX > ctrl.pos) begin
          data_nxt = prev_q;
        end else if (MY_IDX == ctrl.pos) begin
          data_nxt = wr_val;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctrl.pos) begin
          data_nxt = next_q;
        end
      end
      CELL_SET: begin
        if (MY_IDX == ctrl.pos) begin
          data_nxt = wr_val;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== rtl/positional_list_insert_erase.sv =====
// Positional list top level: controller and chain of CAPACITY cells.
// Insert, get and set: result registered at the accepting edge.
// Erase of n values (clamped): one shift of the chain per cycle, result with the last shift.
// Throughput: one item per cycle while the output is not stalled, an erase holding the input until its run ends.
// Reset (synchronous, rst_n low) empties the list; cell contents are not
// cleared and are never read before they are written.
module positional_list_insert_erase #(
  parameter int CAPACITY   = plie_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plie_pkg::DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  plie_in_if.sink    in_ch,
  plie_out_if.source out_ch
);
  import plie_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = (LW > FIELD_POS_W) ? LW : FIELD_POS_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t                state_r, state_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [IW-1:0]         rem_r, rem_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    read_r, read_nxt;
  logic [LW-1:0]         out_len_r, out_len_nxt;
  status_t               status_r, status_nxt;

  logic                  acc;
  opcode_t               op;
  logic [IW-1:0]         pos_w, len_w, cnt_w, avail, n_eff;
  logic                  ins_bad, full, pos_lt, erase_ok, erase_multi, rem_last;
  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] wr_val;
  logic [63:0]           rd_ext;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  // decode
  assign acc         = in_ch.valid && in_ch.ready;
  assign op          = opcode_t'(in_ch.opcode);
  assign pos_w       = IW'(in_ch.position);
  assign cnt_w       = IW'(in_ch.count);
  assign len_w       = IW'(len_r);
  assign ins_bad     = pos_w > len_w;
  assign full        = len_r == LW'(CAPACITY);
  assign pos_lt      = pos_w < len_w;
  assign avail       = len_w - pos_w;
  assign n_eff       = (cnt_w > avail) ? avail : cnt_w;
  assign erase_ok    = pos_lt && (cnt_w != '0);
  assign erase_multi = n_eff > IW'(1);
  assign rem_last    = rem_r == IW'(1);

  assign val_ext = {{(64 - VALUE_W){in_ch.value[VALUE_W-1]}}, in_ch.value};
  assign wr_val  = val_ext[DATA_WIDTH-1:0];
  assign rd_ext  = 64'($signed(cell_q[pos_w[AW-1:0]]));

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && op == OP_ERASE && erase_ok && erase_multi) begin
          state_nxt = S_ERASE;
        end
      end
      S_ERASE: begin
        if (rem_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.pos      = POS_W'(pos_w);
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    read_nxt      = read_r;
    out_len_nxt   = out_len_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          read_nxt      = '0;
          status_nxt    = ST_DONE;
          out_len_nxt   = len_r;
          unique case (op)
            OP_INSERT: begin
              if (ins_bad) begin
                status_nxt = ST_BAD;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctrl.op     = CELL_INS;
                len_nxt     = len_r + LW'(1);
                out_len_nxt = len_nxt;
              end
            end
            OP_ERASE: begin
              if (!erase_ok) begin
                status_nxt = ST_BAD;
              end else begin
                ctrl.op     = CELL_DEL;
                len_nxt     = len_r - LW'(1);
                out_len_nxt = len_nxt;
                if (erase_multi) begin
                  out_valid_nxt = 1'b0;
                  rem_nxt       = n_eff - IW'(1);
                  pos_nxt       = pos_w;
                end
              end
            end
            OP_GET: begin
              if (pos_lt) begin
                read_nxt = rd_ext[VALUE_W-1:0];
              end else begin
                status_nxt = ST_BAD;
              end
            end
            OP_SET: begin
              if (pos_lt) begin
                ctrl.op = CELL_SET;
              end else begin
                status_nxt = ST_BAD;
              end
            end
            default: status_nxt = ST_BAD;
          endcase
        end
      end
      S_ERASE: begin
        ctrl.op  = CELL_DEL;
        ctrl.pos = POS_W'(pos_r);
        len_nxt  = len_r - LW'(1);
        rem_nxt  = rem_r - IW'(1);
        if (rem_last) begin
          out_valid_nxt = 1'b1;
          read_nxt      = '0;
          status_nxt    = ST_DONE;
          out_len_nxt   = len_nxt;
        end
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    read_r    <= read_nxt;
    out_len_r <= out_len_nxt;
    status_r  <= status_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = read_r;
  assign out_ch.list_length = FIELD_POS_W'(out_len_r);
  assign out_ch.status      = status_r;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d, next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_l
      assign prev_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_r
      assign next_d = cell_q[i+1];
    end
    plie_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .wr_val (wr_val),
      .prev_q (prev_d),
      .next_q (next_d),
      .q      (cell_q[i])
    );
  end

  a_erase_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ERASE |-> !out_valid_r)
    else $error("result pending during erase run");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("length above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op == OP_INSERT && !ins_bad && !full |=> len_r == $past(len_r) + LW'(1))
    else $error("insert did not grow the list");

  a_erase_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ERASE |-> rem_r != '0)
    else $error("erase run with nothing left");

endmodule
